// ===== design/mpt_pkg.sv =====
// Shared types and codes of the multimode PLC timer.
package mpt_pkg;

  // Opcodes carried in the input tuser
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_ARM    = 3'd4;
  localparam logic [2:0] OP_KICK   = 3'd5;
  localparam logic [2:0] OP_DISARM = 3'd6;
  localparam logic [2:0] OP_RESET  = 3'd7;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNSUP     = 3'd1;
  localparam logic [2:0] ST_NOT_ARMED = 3'd2;
  localparam logic [2:0] ST_ARMED     = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;

  // Timer kinds
  localparam logic [3:0] K_TON    = 4'd0;
  localparam logic [3:0] K_TOF    = 4'd1;
  localparam logic [3:0] K_TP     = 4'd2;
  localparam logic [3:0] K_MINON  = 4'd3;
  localparam logic [3:0] K_MINOFF = 4'd4;
  localparam logic [3:0] K_WD     = 4'd5;
  localparam logic [3:0] K_WIN_A  = 4'd6;
  localparam logic [3:0] K_MAX    = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] R_ENABLE   = 2'd0;
  localparam logic [1:0] R_KIND     = 2'd1;
  localparam logic [1:0] R_DURATION = 2'd2;
  localparam logic [1:0] R_INIT_LVL = 2'd3;

  localparam logic [31:0] DURATION_RESET = 32'd1000;

  typedef struct packed {
    logic level;
    logic active;
    logic timing;
    logic done;
    logic expired;
    logic armed;
  } flags_t;

  // Update control from the next-state logic
  typedef struct packed {
    logic [2:0] status;
    logic       changed;
    logic       flag_change;
  } ctl_t;

endpackage

// ===== design/multimode_plc_timer.sv =====
// Top level of the multimode PLC timer: state, configuration and stream ports.
//
//  channel  | direction | payload
//  s_*      | in        | tuser: opcode; tdata: level_in, now
//  m_*      | out       | tdata: status, flags, elapsed, remaining, transition, count
//  cfg_*    | in        | cfg_index selects register, cfg_data carries value
//
// One item per cycle while the output is not stalled; its result appears in the cycle
// after the transfer, from the output register fed by a single pass of the next-state logic.
// The input is taken whenever the output register is empty or being drained, so
// a stalled output stalls the input in the same cycle. Synchronous reset restores
// the configuration defaults and the idle timer state; configuration is always ready.
module multimode_plc_timer #(
  parameter int TIME_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [2:0]    s_tuser,   // opcode[2:0]
  input  logic [39:0]   s_tdata,   // level_in[0], now[32:1], zero pad
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,   // status_code[2:0], is_active[3], is_timing[4],
                                   // is_done[5], is_expired[6], is_armed[7],
                                   // level_seen[8], elapsed_time[40:9],
                                   // remaining_time[72:41], transition_time[104:73],
                                   // change_count[136:105], zero pad
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  // Configuration
  logic        timer_enable;
  logic [3:0]  timer_kind;
  logic [31:0] duration;
  logic        initial_level;

  // Timer state
  mpt_pkg::flags_t       flags;
  logic [TIME_WIDTH-1:0] start_stamp;
  logic [31:0]           elapsed;
  logic [31:0]           remaining;
  logic [TIME_WIDTH-1:0] input_change_stamp;
  logic [TIME_WIDTH-1:0] transition_stamp;
  logic [31:0]           change_counter;

  mpt_pkg::flags_t       flags_next;
  logic [TIME_WIDTH-1:0] start_next;
  logic [31:0]           elapsed_next;
  logic [31:0]           remaining_next;
  logic [TIME_WIDTH-1:0] ichg_next;
  logic [TIME_WIDTH-1:0] stamp;
  logic [TIME_WIDTH-1:0] transition_next;
  logic [31:0]           counter_next;
  mpt_pkg::ctl_t         ctl;
  logic [TIME_WIDTH-1:0] now_t;
  logic                  take;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign take      = s_tvalid && s_tready;
  assign now_t     = TIME_WIDTH'(s_tdata[32:1]);

  mpt_next #(.TIME_WIDTH(TIME_WIDTH)) u_next (
    .flags              (flags),
    .start_stamp        (start_stamp),
    .elapsed            (elapsed),
    .remaining          (remaining),
    .input_change_stamp (input_change_stamp),
    .timer_enable       (timer_enable),
    .timer_kind         (timer_kind),
    .duration           (duration),
    .opcode             (s_tuser),
    .level_in           (s_tdata[0]),
    .now_t              (now_t),
    .flags_next         (flags_next),
    .start_next         (start_next),
    .elapsed_next       (elapsed_next),
    .remaining_next     (remaining_next),
    .ichg_next          (ichg_next),
    .stamp              (stamp),
    .ctl                (ctl)
  );

  assign counter_next    = ctl.changed ? change_counter + 32'd1 : change_counter;
  assign transition_next = ctl.flag_change ? stamp : transition_stamp;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_enable  <= 1'b1;
      timer_kind    <= mpt_pkg::K_TON;
      duration      <= mpt_pkg::DURATION_RESET;
      initial_level <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpt_pkg::R_ENABLE:   timer_enable  <= cfg_data[0];
        mpt_pkg::R_KIND:     timer_kind    <= cfg_data[3:0];
        mpt_pkg::R_DURATION: duration      <= cfg_data;
        mpt_pkg::R_INIT_LVL: initial_level <= cfg_data[0];
      endcase
    end
  end

  // Timer state; reset leaves the ON-delay kind idle at time zero
  always_ff @(posedge clk) begin
    if (rst) begin
      flags              <= '{level: initial_level, default: 1'b0};
      start_stamp        <= '0;
      elapsed            <= '0;
      remaining          <= mpt_pkg::DURATION_RESET;
      input_change_stamp <= '0;
      transition_stamp   <= '0;
      change_counter     <= '0;
    end else if (take && ctl.changed) begin
      flags              <= flags_next;
      start_stamp        <= start_next;
      elapsed            <= elapsed_next;
      remaining          <= remaining_next;
      input_change_stamp <= ichg_next;
      transition_stamp   <= transition_next;
      change_counter     <= counter_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {7'd0, counter_next, 32'(transition_next), remaining_next, elapsed_next,
                  flags_next.level, flags_next.armed, flags_next.expired, flags_next.done,
                  flags_next.timing, flags_next.active, ctl.status};
    end
  end

  // Checks
  a_reset_op_clears: assert property (@(posedge clk) disable iff (rst)
    take && s_tuser == mpt_pkg::OP_RESET |=>
      !flags.active && !flags.timing && !flags.done && !flags.expired && !flags.armed)
    else $error("reset opcode left a flag set");

  a_counter_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(change_counter))
    else $error("change counter moved without a transfer");

  a_timing_done: assert property (@(posedge clk) disable iff (rst)
    !(flags.timing && flags.done))
    else $error("timer both timing and done");

  a_error_no_update: assert property (@(posedge clk) disable iff (rst)
    take && ctl.status != mpt_pkg::ST_OK |=> $stable(change_counter))
    else $error("rejected opcode changed state");

endmodule

// ===== design/mpt_next.sv =====
// Next-state logic of the timer: opcode handling, evaluation and change detection.
module mpt_next #(
  parameter int TIME_WIDTH = 32
) (
  input  mpt_pkg::flags_t        flags,
  input  logic [TIME_WIDTH-1:0]  start_stamp,
  input  logic [31:0]            elapsed,
  input  logic [31:0]            remaining,
  input  logic [TIME_WIDTH-1:0]  input_change_stamp,
  input  logic                   timer_enable,
  input  logic [3:0]             timer_kind,
  input  logic [31:0]            duration,
  input  logic [2:0]             opcode,
  input  logic                   level_in,
  input  logic [TIME_WIDTH-1:0]  now_t,
  output mpt_pkg::flags_t        flags_next,
  output logic [TIME_WIDTH-1:0]  start_next,
  output logic [31:0]            elapsed_next,
  output logic [31:0]            remaining_next,
  output logic [TIME_WIDTH-1:0]  ichg_next,
  output logic [TIME_WIDTH-1:0]  stamp,
  output mpt_pkg::ctl_t          ctl
);

  localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  typedef struct packed {
    mpt_pkg::flags_t        f;
    logic [TIME_WIDTH-1:0]  start;
    logic [31:0]            el;
    logic [31:0]            rem;
    logic [TIME_WIDTH-1:0]  ichg;
  } tstate_t;

  function automatic tstate_t go_idle(tstate_t si, logic [31:0] dur);
    tstate_t s;
    s          = si;
    s.f.active = 1'b0;
    s.f.timing = 1'b0;
    s.f.done   = 1'b0;
    s.f.expired = 1'b0;
    s.f.armed  = 1'b0;
    s.start    = '0;
    s.el       = '0;
    s.rem      = dur;
    return s;
  endfunction

  // Time since start, zero when not past it, saturated at the duration
  function automatic logic [31:0] elapsed_at(logic [TIME_WIDTH-1:0] nw,
                                             logic [TIME_WIDTH-1:0] st,
                                             logic [31:0] dur);
    logic [TIME_WIDTH-1:0] d;
    logic [CW-1:0]         dx;
    d  = nw - st;
    dx = CW'(d);
    if (nw <= st) return '0;
    else if (dx < CW'(dur)) return 32'(dx);
    else return dur;
  endfunction

  function automatic tstate_t hold_done(tstate_t si, logic act, logic [31:0] dur);
    tstate_t s;
    s          = si;
    s.f.active = act;
    s.f.timing = 1'b0;
    s.f.done   = 1'b1;
    s.el       = dur;
    s.rem      = '0;
    return s;
  endfunction

  function automatic tstate_t evaluate(tstate_t si, logic [TIME_WIDTH-1:0] nw,
                                       logic auto_go, logic en, logic [3:0] kind,
                                       logic [31:0] dur);
    tstate_t     s;
    logic [31:0] e;
    logic        full;
    s    = si;
    e    = elapsed_at(nw, si.start, dur);
    full = 1'b0;
    if (!en || kind > mpt_pkg::K_MAX) begin
      s = go_idle(s, dur);
    end else begin
      case (kind)
        mpt_pkg::K_TON: begin
          if (!s.f.level) begin
            s = go_idle(s, dur);
          end else begin
            if (!s.f.active && !s.f.done && !s.f.timing && auto_go) begin
              s.f.timing = 1'b1;
              s.start    = nw;
              e          = '0;
            end
            if (s.f.timing) begin
              full       = (e >= dur);
              s.el       = e;
              s.rem      = dur - e;
              s.f.active = full;
              s.f.timing = !full;
              s.f.done   = full;
            end else if (s.f.active || s.f.done) begin
              s = hold_done(s, 1'b1, dur);
            end else begin
              s.el  = '0;
              s.rem = dur;
            end
          end
        end
        mpt_pkg::K_TOF, mpt_pkg::K_TP: begin
          if (kind == mpt_pkg::K_TOF && s.f.level) begin
            s.f.active = 1'b1;
            s.f.timing = 1'b0;
            s.f.done   = 1'b0;
            s.start    = '0;
            s.el       = '0;
            s.rem      = '0;
          end else if (s.f.timing || (kind == mpt_pkg::K_TP && s.f.active)) begin
            full       = (e >= dur);
            s.el       = e;
            s.rem      = dur - e;
            s.f.active = !full;
            s.f.timing = !full;
            s.f.done   = full;
          end else if (s.f.done) begin
            s = hold_done(s, 1'b0, dur);
          end else begin
            s = go_idle(s, dur);
          end
        end
        mpt_pkg::K_MINON: begin
          if (s.f.level && !s.f.active && auto_go) begin
            s.f.active = 1'b1;
            s.f.timing = 1'b1;
            s.f.done   = 1'b0;
            s.start    = nw;
            e          = '0;
          end
          if (s.f.active) begin
            s.el  = e;
            s.rem = dur - e;
            if (e >= dur) begin
              if (s.f.level) begin
                s.f.active = 1'b1;
                s.f.timing = 1'b0;
                s.f.done   = 1'b1;
              end else begin
                s = go_idle(s, dur);
              end
            end else begin
              s.f.active = 1'b1;
              s.f.timing = 1'b1;
              s.f.done   = 1'b0;
            end
          end else begin
            s = go_idle(s, dur);
          end
        end
        mpt_pkg::K_MINOFF: begin
          if (s.f.timing) begin
            s.el  = e;
            s.rem = dur - e;
            if (e >= dur) begin
              s.f.timing = 1'b0;
              s.f.done   = 1'b1;
              s.f.active = s.f.level;
            end else begin
              s.f.active = 1'b0;
              s.f.done   = 1'b0;
            end
          end else if (s.f.level) begin
            s.f.active = 1'b1;
            s.f.timing = 1'b0;
            s.el       = s.f.done ? dur : '0;
            s.rem      = '0;
          end else if (s.f.done) begin
            s = hold_done(s, 1'b0, dur);
          end else begin
            s = go_idle(s, dur);
          end
        end
        mpt_pkg::K_WD: begin
          if (!s.f.armed) begin
            s = go_idle(s, dur);
          end else if (s.f.expired) begin
            s.f.active = 1'b1;
            s.f.timing = 1'b0;
            s.f.done   = 1'b0;
            s.el       = dur;
            s.rem      = '0;
          end else begin
            s.el        = e;
            s.rem       = dur - e;
            s.f.active  = 1'b1;
            s.f.timing  = (e < dur);
            s.f.done    = 1'b0;
            s.f.expired = (e >= dur);
          end
        end
        mpt_pkg::K_MAX: begin
          if (s.f.armed) begin
            full        = (e >= dur);
            s.el        = e;
            s.rem       = dur - e;
            s.f.armed   = !full;
            s.f.active  = !full;
            s.f.timing  = !full;
            s.f.done    = 1'b0;
            s.f.expired = full;
          end else if (s.f.expired) begin
            s.f.active = 1'b0;
            s.f.timing = 1'b0;
            s.f.done   = 1'b0;
            s.el       = dur;
            s.rem      = '0;
          end else begin
            s = go_idle(s, dur);
          end
        end
        default: begin
          // window kinds
          if (!s.f.armed) begin
            s.f.active  = 1'b0;
            s.f.timing  = 1'b0;
            s.f.expired = 1'b0;
            s.el        = s.f.done ? dur : '0;
            s.rem       = s.f.done ? '0 : dur;
          end else begin
            full       = (e >= dur);
            s.el       = e;
            s.rem      = dur - e;
            s.f.armed  = !full;
            s.f.active = !full;
            s.f.timing = !full;
            s.f.done   = full;
          end
        end
      endcase
    end
    return s;
  endfunction

  function automatic tstate_t arm_fields(tstate_t si, logic [TIME_WIDTH-1:0] nw,
                                         logic [31:0] dur);
    tstate_t s;
    s           = si;
    s.f.armed   = 1'b1;
    s.f.active  = 1'b1;
    s.f.timing  = 1'b1;
    s.f.done    = 1'b0;
    s.f.expired = 1'b0;
    s.start     = nw;
    s.el        = '0;
    s.rem       = dur;
    return s;
  endfunction

  tstate_t    cur;
  tstate_t    cand;
  tstate_t    res;
  logic       do_eval;
  logic       auto_go;
  logic       prev;
  logic       is_win;
  logic       is_wd;
  logic [2:0] status;

  assign cur    = '{f: flags, start: start_stamp, el: elapsed, rem: remaining,
                    ichg: input_change_stamp};
  assign is_win = (timer_kind >= mpt_pkg::K_WIN_A) && (timer_kind <= mpt_pkg::K_MAX);
  assign is_wd  = (timer_kind == mpt_pkg::K_WD);

  // Candidate state per opcode, before evaluation
  always_comb begin
    cand    = cur;
    status  = mpt_pkg::ST_OK;
    do_eval = 1'b0;
    auto_go = 1'b0;
    prev    = cur.f.level;
    stamp   = now_t;
    unique case (opcode)
      mpt_pkg::OP_TICK: begin
        do_eval = 1'b1;
        auto_go = 1'b1;
      end
      mpt_pkg::OP_SET: begin
        if (timer_kind > mpt_pkg::K_MINOFF) begin
          status = mpt_pkg::ST_UNSUP;
        end else begin
          if (prev != level_in) begin
            cand.f.level = level_in;
            cand.ichg    = now_t;
          end
          if ((timer_kind == mpt_pkg::K_TOF && prev && !level_in) ||
              ((timer_kind == mpt_pkg::K_TP || timer_kind == mpt_pkg::K_MINON) &&
               !prev && level_in)) begin
            cand.start    = now_t;
            cand.f.active = 1'b1;
            cand.f.timing = 1'b1;
            cand.f.done   = 1'b0;
            if (timer_kind == mpt_pkg::K_TP) cand.f.expired = 1'b0;
          end else if (timer_kind == mpt_pkg::K_MINOFF && prev && !level_in &&
                       cur.f.active) begin
            cand.start    = now_t;
            cand.f.active = 1'b0;
            cand.f.timing = 1'b1;
            cand.f.done   = 1'b0;
          end
          do_eval = 1'b1;
          auto_go = 1'b1;
        end
      end
      mpt_pkg::OP_START, mpt_pkg::OP_STOP: begin
        if (!is_win) begin
          status = mpt_pkg::ST_UNSUP;
        end else begin
          cand    = (opcode == mpt_pkg::OP_START) ? arm_fields(cur, now_t, duration)
                                                  : go_idle(cur, duration);
          do_eval = 1'b1;
        end
      end
      mpt_pkg::OP_ARM: begin
        if (!is_wd) status = mpt_pkg::ST_UNSUP;
        else if (cur.f.armed) status = mpt_pkg::ST_ARMED;
        else begin
          cand    = arm_fields(cur, now_t, duration);
          do_eval = 1'b1;
        end
      end
      mpt_pkg::OP_KICK: begin
        if (!is_wd) status = mpt_pkg::ST_UNSUP;
        else if (!cur.f.armed) status = mpt_pkg::ST_NOT_ARMED;
        else if (cur.f.expired) status = mpt_pkg::ST_EXPIRED;
        else begin
          cand.start    = now_t;
          cand.f.active = 1'b1;
          cand.f.timing = 1'b1;
          cand.f.done   = 1'b0;
          cand.el       = '0;
          cand.rem      = duration;
          do_eval       = 1'b1;
        end
      end
      mpt_pkg::OP_DISARM: begin
        if (!is_wd) status = mpt_pkg::ST_UNSUP;
        else if (!cur.f.armed) status = mpt_pkg::ST_NOT_ARMED;
        else begin
          cand    = go_idle(cur, duration);
          do_eval = 1'b1;
        end
      end
      mpt_pkg::OP_RESET: begin
        // applies regardless of enable; stamps zero
        cand  = go_idle(cur, duration);
        stamp = '0;
      end
    endcase
  end

  assign res = do_eval ? evaluate(cand, now_t, auto_go, timer_enable, timer_kind, duration)
                       : cand;

  assign flags_next      = res.f;
  assign start_next      = res.start;
  assign elapsed_next    = res.el;
  assign remaining_next  = res.rem;
  assign ichg_next       = res.ichg;
  assign ctl.status      = status;
  assign ctl.changed     = (res != cur);
  assign ctl.flag_change = (res.f != cur.f);

endmodule

// ===== tb/multimode_plc_timer_tb.sv =====
// Self-checking testbench of the multimode PLC timer: directed and random transfers.
`timescale 1ns / 100ps

module multimode_plc_timer_tb;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [2:0]   s_tuser;
  logic [39:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  multimode_plc_timer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct {
    bit        level, active, timing, done, expired, armed;
    bit [31:0] start, elapsed, remaining, ichg;
  } tmr_state_t;

  typedef struct {
    bit [2:0]  status;
    bit        active, timing, done, expired, armed, level;
    bit [31:0] elapsed, remaining, trans, count;
  } tmr_result_t;

  // Timer model state and its copy of the configuration
  tmr_state_t  tmr;
  bit [31:0]   trans_stamp;
  bit [31:0]   upd_count;
  bit          cfg_en;
  bit [3:0]    cfg_kind;
  bit [31:0]   cfg_dur;

  tmr_result_t pending_results[$];
  int          errors;
  int          mismatches;
  bit          idle_on;
  int          hold_req;
  bit [31:0]   cur_now;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  function automatic tmr_state_t go_idle(tmr_state_t s);
    s.active = 0; s.timing = 0; s.done = 0; s.expired = 0; s.armed = 0;
    s.start = 0; s.elapsed = 0; s.remaining = cfg_dur;
    return s;
  endfunction

  function automatic bit [31:0] span(bit [31:0] now, bit [31:0] start);
    bit [31:0] d;
    if (now <= start) return 0;
    d = now - start;
    return (d < cfg_dur) ? d : cfg_dur;
  endfunction

  function automatic tmr_state_t put_elapsed(tmr_state_t s, bit [31:0] e);
    s.elapsed = (e < cfg_dur) ? e : cfg_dur;
    s.remaining = cfg_dur - s.elapsed;
    return s;
  endfunction

  function automatic tmr_state_t held_done(tmr_state_t s, bit act);
    s.active = act; s.timing = 0; s.done = 1;
    s.elapsed = cfg_dur; s.remaining = 0;
    return s;
  endfunction

  // Re-evaluation of the timer at a timestamp
  function automatic tmr_state_t settle(tmr_state_t s, bit [31:0] now, bit auto_go);
    bit [31:0] e;
    bit        full;
    if (!cfg_en || cfg_kind > mpt_pkg::K_MAX) return go_idle(s);
    case (cfg_kind)
      mpt_pkg::K_TON: begin
        if (!s.level) return go_idle(s);
        if (!s.active && !s.done && !s.timing && auto_go) begin
          s.timing = 1; s.start = now;
        end
        if (s.timing) begin
          e = span(now, s.start);
          s = put_elapsed(s, e);
          full = e >= cfg_dur;
          s.active = full; s.timing = !full; s.done = full;
        end else if (s.active || s.done) begin
          s = held_done(s, 1);
        end else begin
          s.elapsed = 0; s.remaining = cfg_dur;
        end
      end
      mpt_pkg::K_TOF, mpt_pkg::K_TP: begin
        if (cfg_kind == mpt_pkg::K_TOF && s.level) begin
          s.active = 1; s.timing = 0; s.done = 0;
          s.start = 0; s.elapsed = 0; s.remaining = 0;
        end else if (s.timing || (cfg_kind == mpt_pkg::K_TP && s.active)) begin
          e = span(now, s.start);
          s = put_elapsed(s, e);
          full = e >= cfg_dur;
          s.active = !full; s.timing = !full; s.done = full;
        end else if (s.done) begin
          s = held_done(s, 0);
        end else begin
          s = go_idle(s);
        end
      end
      mpt_pkg::K_MINON: begin
        if (s.level && !s.active && auto_go) begin
          s.active = 1; s.timing = 1; s.done = 0; s.start = now;
        end
        if (s.active) begin
          e = span(now, s.start);
          s = put_elapsed(s, e);
          if (e >= cfg_dur) begin
            if (s.level) begin
              s.active = 1; s.timing = 0; s.done = 1;
            end else begin
              s = go_idle(s);
            end
          end else begin
            s.active = 1; s.timing = 1; s.done = 0;
          end
        end else begin
          s = go_idle(s);
        end
      end
      mpt_pkg::K_MINOFF: begin
        if (s.timing) begin
          e = span(now, s.start);
          s = put_elapsed(s, e);
          if (e >= cfg_dur) begin
            s.timing = 0; s.done = 1; s.active = s.level;
          end else begin
            s.active = 0; s.done = 0;
          end
        end else if (s.level) begin
          s.active = 1; s.timing = 0;
          s.elapsed = s.done ? cfg_dur : 0;
          s.remaining = 0;
        end else if (s.done) begin
          s = held_done(s, 0);
        end else begin
          s = go_idle(s);
        end
      end
      mpt_pkg::K_WD: begin
        if (!s.armed) return go_idle(s);
        if (s.expired) begin
          s.active = 1; s.timing = 0; s.done = 0;
          s.elapsed = cfg_dur; s.remaining = 0;
        end else begin
          e = span(now, s.start);
          s = put_elapsed(s, e);
          s.active = 1; s.timing = e < cfg_dur; s.done = 0;
          s.expired = e >= cfg_dur;
        end
      end
      mpt_pkg::K_MAX: begin
        if (s.armed) begin
          e = span(now, s.start);
          s = put_elapsed(s, e);
          full = e >= cfg_dur;
          s.armed = !full; s.active = !full; s.timing = !full;
          s.done = 0; s.expired = full;
        end else if (s.expired) begin
          s.active = 0; s.timing = 0; s.done = 0;
          s.elapsed = cfg_dur; s.remaining = 0;
        end else begin
          s = go_idle(s);
        end
      end
      default: begin
        // one-shot window kinds
        if (!s.armed) begin
          s.active = 0; s.timing = 0; s.expired = 0;
          s.elapsed = s.done ? cfg_dur : 0;
          s.remaining = s.done ? 0 : cfg_dur;
        end else begin
          e = span(now, s.start);
          s = put_elapsed(s, e);
          full = e >= cfg_dur;
          s.armed = !full; s.active = !full; s.timing = !full; s.done = full;
        end
      end
    endcase
    return s;
  endfunction

  function automatic tmr_state_t armed_fields(tmr_state_t s, bit [31:0] now);
    s.armed = 1; s.active = 1; s.timing = 1; s.done = 0; s.expired = 0;
    s.start = now; s.elapsed = 0; s.remaining = cfg_dur;
    return s;
  endfunction

  function automatic void store_state(tmr_state_t c, bit [31:0] stamp);
    bit fl;
    fl = c.level != tmr.level || c.active != tmr.active || c.timing != tmr.timing ||
         c.done != tmr.done || c.expired != tmr.expired || c.armed != tmr.armed;
    if (fl || c.start != tmr.start || c.elapsed != tmr.elapsed ||
        c.remaining != tmr.remaining || c.ichg != tmr.ichg) begin
      upd_count++;
      if (fl) trans_stamp = stamp;
      tmr = c;
    end
  endfunction

  function automatic void timer_reset_state();
    cfg_en = 1; cfg_kind = mpt_pkg::K_TON; cfg_dur = mpt_pkg::DURATION_RESET;
    tmr = '{default: 0};
    tmr = go_idle(tmr);
    tmr = settle(tmr, 0, 1);
    trans_stamp = 0;
    upd_count = 0;
  endfunction

  // Applies one item to the model and returns the expected result after it
  function automatic tmr_result_t timer_apply(bit [2:0] op, bit lv, bit [31:0] now);
    tmr_state_t  c;
    tmr_result_t r;
    bit [2:0]    status;
    bit          prev;
    bit          is_win;
    bit          is_wd;
    c = tmr;
    status = mpt_pkg::ST_OK;
    is_win = cfg_kind >= mpt_pkg::K_WIN_A && cfg_kind <= mpt_pkg::K_MAX;
    is_wd = cfg_kind == mpt_pkg::K_WD;
    case (op)
      mpt_pkg::OP_TICK: store_state(settle(c, now, 1), now);
      mpt_pkg::OP_SET: begin
        if (cfg_kind > mpt_pkg::K_MINOFF) begin
          status = mpt_pkg::ST_UNSUP;
        end else begin
          prev = c.level;
          if (prev != lv) begin
            c.level = lv; c.ichg = now;
          end
          if ((cfg_kind == mpt_pkg::K_TOF && prev && !lv) ||
              ((cfg_kind == mpt_pkg::K_TP || cfg_kind == mpt_pkg::K_MINON) &&
               !prev && lv)) begin
            c.start = now; c.active = 1; c.timing = 1; c.done = 0;
            if (cfg_kind == mpt_pkg::K_TP) c.expired = 0;
          end else if (cfg_kind == mpt_pkg::K_MINOFF && prev && !lv && tmr.active) begin
            c.start = now; c.active = 0; c.timing = 1; c.done = 0;
          end
          store_state(settle(c, now, 1), now);
        end
      end
      mpt_pkg::OP_START, mpt_pkg::OP_STOP: begin
        if (!is_win) begin
          status = mpt_pkg::ST_UNSUP;
        end else begin
          c = (op == mpt_pkg::OP_START) ? armed_fields(c, now) : go_idle(c);
          store_state(settle(c, now, 0), now);
        end
      end
      mpt_pkg::OP_ARM: begin
        if (!is_wd) status = mpt_pkg::ST_UNSUP;
        else if (tmr.armed) status = mpt_pkg::ST_ARMED;
        else store_state(settle(armed_fields(c, now), now, 0), now);
      end
      mpt_pkg::OP_KICK: begin
        if (!is_wd) status = mpt_pkg::ST_UNSUP;
        else if (!tmr.armed) status = mpt_pkg::ST_NOT_ARMED;
        else if (tmr.expired) status = mpt_pkg::ST_EXPIRED;
        else begin
          c.start = now; c.active = 1; c.timing = 1; c.done = 0;
          c.elapsed = 0; c.remaining = cfg_dur;
          store_state(settle(c, now, 0), now);
        end
      end
      mpt_pkg::OP_DISARM: begin
        if (!is_wd) status = mpt_pkg::ST_UNSUP;
        else if (!tmr.armed) status = mpt_pkg::ST_NOT_ARMED;
        else store_state(settle(go_idle(c), now, 0), now);
      end
      default: store_state(go_idle(c), 0);
    endcase
    r.status = status;
    r.active = tmr.active; r.timing = tmr.timing; r.done = tmr.done;
    r.expired = tmr.expired; r.armed = tmr.armed; r.level = tmr.level;
    r.elapsed = tmr.elapsed; r.remaining = tmr.remaining;
    r.trans = trans_stamp; r.count = upd_count;
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    tmr_result_t want;
    tmr_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[2:0];
      got.active = m_tdata[3]; got.timing = m_tdata[4]; got.done = m_tdata[5];
      got.expired = m_tdata[6]; got.armed = m_tdata[7]; got.level = m_tdata[8];
      got.elapsed = m_tdata[40:9]; got.remaining = m_tdata[72:41];
      got.trans = m_tdata[104:73]; got.count = m_tdata[136:105];
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result transfer at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.active != want.active ||
            got.timing != want.timing || got.done != want.done ||
            got.expired != want.expired || got.armed != want.armed ||
            got.level != want.level || got.elapsed != want.elapsed ||
            got.remaining != want.remaining || got.trans != want.trans ||
            got.count != want.count) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display({"mismatch at %0t: exp st=%0d flags(a t d x r l)=%b%b%b%b%b%b",
                      " el=%0d rem=%0d tr=%0d cnt=%0d"},
                     $realtime, want.status, want.active, want.timing, want.done,
                     want.expired, want.armed, want.level, want.elapsed,
                     want.remaining, want.trans, want.count);
            $display({"            got st=%0d flags(a t d x r l)=%b%b%b%b%b%b",
                      " el=%0d rem=%0d tr=%0d cnt=%0d"},
                     got.status, got.active, got.timing, got.done, got.expired,
                     got.armed, got.level, got.elapsed, got.remaining, got.trans,
                     got.count);
          end
        end
      end
    end
  end

  // Receiver: random stall bursts and the long hold-off on request
  initial begin
    int stall_left;
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        m_tready = 1'b0;
        hold_req--;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // One input transfer; the model is advanced when it is accepted
  task automatic send_item(bit [2:0] op, bit lv, bit [31:0] now);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tuser = op;
    s_tdata = {7'd0, now, lv};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.insert(pending_results.size(), timer_apply(op, lv, now));
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write, only with the block drained
  task automatic write_reg(bit [1:0] idx, bit [31:0] val);
    drain_results();
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mpt_pkg::R_ENABLE:   cfg_en = val[0];
      mpt_pkg::R_KIND:     cfg_kind = val[3:0];
      mpt_pkg::R_DURATION: cfg_dur = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(bit en, bit [3:0] kind, bit [31:0] dur);
    write_reg(mpt_pkg::R_ENABLE, 32'(en));
    write_reg(mpt_pkg::R_KIND, 32'(kind));
    write_reg(mpt_pkg::R_DURATION, dur);
  endtask

  // Directed: some kinds, each status, the extremes of time and duration
  task automatic test_directed();
    send_item(mpt_pkg::OP_TICK, 0, 0);
    send_item(mpt_pkg::OP_SET, 1, 10);
    send_item(mpt_pkg::OP_TICK, 0, 500);
    send_item(mpt_pkg::OP_TICK, 1, 1010);
    send_item(mpt_pkg::OP_ARM, 0, 1020);
    send_item(mpt_pkg::OP_START, 0, 1030);
    send_item(mpt_pkg::OP_RESET, 0, 1040);
    setup(1, mpt_pkg::K_WD, 100);
    send_item(mpt_pkg::OP_KICK, 0, 5);
    send_item(mpt_pkg::OP_DISARM, 0, 6);
    send_item(mpt_pkg::OP_ARM, 0, 10);
    send_item(mpt_pkg::OP_ARM, 0, 20);
    send_item(mpt_pkg::OP_KICK, 0, 50);
    send_item(mpt_pkg::OP_TICK, 0, 300);
    send_item(mpt_pkg::OP_KICK, 0, 310);
    send_item(mpt_pkg::OP_SET, 1, 320);
    send_item(mpt_pkg::OP_DISARM, 0, 330);
    setup(1, mpt_pkg::K_WIN_A, 32'hFFFF_FFFF);
    send_item(mpt_pkg::OP_START, 1, 32'hFFFF_FFFF);
    send_item(mpt_pkg::OP_TICK, 0, 32'd0);
    send_item(mpt_pkg::OP_STOP, 0, 32'h8000_0000);
    setup(1, mpt_pkg::K_MAX, 1);
    send_item(mpt_pkg::OP_START, 0, 100);
    send_item(mpt_pkg::OP_TICK, 0, 99);
    send_item(mpt_pkg::OP_TICK, 0, 102);
    setup(0, mpt_pkg::K_TP, 50);
    send_item(mpt_pkg::OP_SET, 1, 7);
    send_item(mpt_pkg::OP_RESET, 0, 8);
    write_reg(mpt_pkg::R_INIT_LVL, 1);
    setup(1, 4'd15, 50);
    send_item(mpt_pkg::OP_ARM, 0, 9);
    send_item(mpt_pkg::OP_TICK, 0, 9);
  endtask

  function automatic bit [2:0] pick_op();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) return mpt_pkg::OP_RESET;
    if (p < 8) return 3'($urandom);
    if (p < 40) return mpt_pkg::OP_TICK;
    if (cfg_kind <= mpt_pkg::K_MINOFF) return (p < 85) ? mpt_pkg::OP_SET : mpt_pkg::OP_TICK;
    if (cfg_kind == mpt_pkg::K_WD) begin
      if (p < 55) return mpt_pkg::OP_ARM;
      return (p < 88) ? mpt_pkg::OP_KICK : mpt_pkg::OP_DISARM;
    end
    if (cfg_kind <= mpt_pkg::K_MAX) return (p < 80) ? mpt_pkg::OP_START : mpt_pkg::OP_STOP;
    return 3'($urandom);
  endfunction

  // Random phases, each with its own configuration
  task automatic test_random(int phases, int per_phase);
    bit [31:0] dur;
    bit [31:0] step_max;
    int        sel;
    for (int ph = 0; ph < phases; ph++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) dur = 32'hFFFF_FFFF;
      else if (sel == 1) dur = 1;
      else if (sel == 2) dur = $urandom;
      else dur = $urandom_range(1, 60);
      setup($urandom_range(0, 9) != 0,
            ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9)),
            dur);
      if ($urandom_range(0, 7) == 0) write_reg(mpt_pkg::R_INIT_LVL, $urandom_range(0, 1));
      step_max = (dur > 40) ? 40 : dur + 2;
      for (int i = 0; i < per_phase; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 3) cur_now = $urandom;
        else if (sel < 6) cur_now = cur_now - $urandom_range(0, 20);
        else cur_now = cur_now + $urandom_range(0, step_max);
        send_item(pick_op(), 1'($urandom_range(0, 1)), cur_now);
      end
    end
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    setup(1, mpt_pkg::K_TON, 20);
    hold_req = 300;
    for (int i = 0; i < 30; i++) begin
      cur_now = cur_now + $urandom_range(0, 8);
      send_item(($urandom_range(0, 1) != 0) ? mpt_pkg::OP_SET : mpt_pkg::OP_TICK,
                1'($urandom_range(0, 1)), cur_now);
    end
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    mismatches = 0;
    idle_on = 1'b1;
    hold_req = 0;
    cur_now = 0;
    timer_reset_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random(26, 40);
    idle_on = 1'b0;
    test_random(4, 40);

    drain_results();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mpt_pkg.sv
design/mpt_next.sv
design/multimode_plc_timer.sv
tb/multimode_plc_timer_tb.sv
